### src/spq_pkg.sv
// spq_pkg: shared types and constants for the sorted priority queue.
// No dependencies; imported by spq_cell, sorted_priority_queue and the bench.
package spq_pkg;

  localparam int DEPTH   = 16;
  localparam int DATA_W  = 32;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int OCC_W   = 5;
  localparam int STAT_W  = 2;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_REMOVE = 1'b1
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_UNDERFLOW = 2'd2
  } status_t;

  // Broadcast control for every cell of the row.
  typedef struct packed {
    logic  ins;   // accepted insert that fits
    logic  rem;   // accepted remove on a non-empty queue
    data_t val;   // value being inserted
  } cell_ctl_t;

endpackage

### src/spq_cell.sv
// spq_cell: one slot of the sorted shift-register row.
// Depends on spq_pkg (data_t, cell_ctl_t).
module spq_cell
  import spq_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      occ,        // this slot holds a live entry
  input  logic      prev_gt,    // left neighbor yields to the new value
  input  data_t     prev_entry,
  input  data_t     next_entry,
  output logic      gt,         // new value goes at or left of here
  output data_t     entry
);

  data_t entry_r;
  data_t entry_nxt;

  // Empty slots always yield; equal values stay ahead of the new one.
  assign gt    = !occ || (ctl.val > entry_r);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.ins && gt) begin
      entry_nxt = prev_gt ? prev_entry : ctl.val;
    end else if (ctl.rem) begin
      entry_nxt = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

### src/sorted_priority_queue.sv
// Sorted priority queue: a row of DEPTH cells kept in descending order.
// The result beat is registered; it appears in the cycle after acceptance.
// Throughput: one operation per cycle unless stalled; every cell compares the
// broadcast value in parallel and shifts toward its neighbor in the same cycle.
// Reset (rst_n low, synchronous): fill count and output valid cleared; cell
// contents are left as they are and are never read before being written.
module sorted_priority_queue
  import spq_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  // input channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_func,
  input  logic signed [DATA_W-1:0] in_value,
  // result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [STAT_W-1:0]       out_status,
  output logic signed [DATA_W-1:0] out_removed_value,
  output logic [OCC_W-1:0]        out_occupancy
);

  // Output register: a new beat is taken whenever the held result either
  // leaves this cycle or the register is empty.
  logic                    out_valid_r, out_valid_nxt;
  status_t                 status_r, status_nxt;
  data_t                   removed_r, removed_nxt;
  logic [OCC_W-1:0]        occ_r, occ_nxt;

  cnt_t                    count_r, count_nxt;

  logic                    accept;
  logic                    full, empty;
  cell_ctl_t               ctl;

  // cell row wiring; the first and last cells tie off their missing neighbor
  logic                    gt     [DEPTH];
  data_t                   entry  [DEPTH];
  logic                    occ    [DEPTH];

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign full  = (count_r == cnt_t'(DEPTH));
  assign empty = (count_r == '0);

  // ins, rem, val
  assign ctl = {accept && (in_func == FUNC_INSERT) && !full,
                accept && (in_func == FUNC_REMOVE) && !empty,
                in_value};

  // Thermometer of live slots from the fill count.
  for (genvar i = 0; i < DEPTH; i++) begin : g_row
    assign occ[i] = (cnt_t'(i) < count_r);

    spq_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occ        (occ[i]),
      .prev_gt    ((i == 0) ? 1'b0 : gt[(i == 0) ? 0 : i-1]),
      .prev_entry (entry[(i == 0) ? 0 : i-1]),
      .next_entry (entry[(i == DEPTH-1) ? i : i+1]),
      .gt         (gt[i]),
      .entry      (entry[i])
    );
  end

  // Fill count and result beat.
  always_comb begin
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && out_stall;
    status_nxt    = status_r;
    removed_nxt   = removed_r;
    occ_nxt       = occ_r;
    if (ctl.ins) begin
      count_nxt = count_r + cnt_t'(1);
    end else if (ctl.rem) begin
      count_nxt = count_r - cnt_t'(1);
    end
    if (accept) begin
      out_valid_nxt = 1'b1;
      removed_nxt   = '0;
      if (in_func == FUNC_INSERT) begin
        status_nxt = full ? STAT_OVERFLOW : STAT_OK;
      end else begin
        status_nxt = empty ? STAT_UNDERFLOW : STAT_OK;
        if (!empty) begin
          removed_nxt = entry[0];
        end
      end
      occ_nxt = OCC_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload of the result beat; no reset needed
  always_ff @(posedge clk) begin
    status_r  <= status_nxt;
    removed_r <= removed_nxt;
    occ_r     <= occ_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_removed_value = removed_r;
  assign out_occupancy     = occ_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------

  // Fill count never runs past the row length.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cnt_t'(DEPTH))
    else $error("fill count exceeds depth");

  // Head of the row is no smaller than the second live entry.
  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= cnt_t'(2)) |-> (entry[0] >= entry[1]))
    else $error("row out of order at head");

  // A successful remove reports the head as it stood when accepted.
  a_remove_head: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.rem |=> (out_valid_r && status_r == STAT_OK && removed_r == $past(entry[0])))
    else $error("removed value does not match head");

  // An overflow beat leaves the queue reported as full.
  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_func == FUNC_INSERT && full) |=>
      (status_r == STAT_OVERFLOW && occ_r == OCC_W'(DEPTH)))
    else $error("overflow reported on a queue that is not full");

endmodule

### bench/spq_check_pkg.sv
// spq_check_pkg: ordering model and result checker for the sorted priority queue bench.
// Depends on spq_pkg for widths, data type, operation and status codes.
package spq_check_pkg;
  import spq_pkg::*;

  typedef struct {
    status_t               status;
    data_t                 removed;
    logic [OCC_W-1:0]      occupancy;
  } queue_result_t;

  class queue_scoreboard;
    data_t         held_values[$];   // descending; equal values keep arrival order
    queue_result_t due_results[$];
    int            mismatches;
    int            beats_checked;
    int            n_insert, n_remove, n_overflow, n_underflow, peak_fill;

    function new();
      mismatches    = 0;
      beats_checked = 0;
      n_insert      = 0;
      n_remove      = 0;
      n_overflow    = 0;
      n_underflow   = 0;
      peak_fill     = 0;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    task report(string msg);
      if (mismatches < 40) $display("MISMATCH: %s", msg);
      mismatches++;
    endtask

    // Apply one accepted operation to the model and queue up its result.
    task note_op(func_t op, data_t value);
      queue_result_t res;
      int            slot;
      res.status    = STAT_OK;
      res.removed   = '0;
      if (op == FUNC_INSERT) begin
        n_insert++;
        if (held_values.size() >= DEPTH) begin
          res.status = STAT_OVERFLOW;
          n_overflow++;
        end else begin
          slot = held_values.size();
          for (int k = 0; k < held_values.size(); k++) begin
            if (held_values[k] < value) begin
              slot = k;
              break;
            end
          end
          held_values.insert(slot, value);
        end
      end else begin
        n_remove++;
        if (held_values.size() == 0) begin
          res.status = STAT_UNDERFLOW;
          n_underflow++;
        end else begin
          res.removed = held_values.pop_front();
        end
      end
      if (held_values.size() > peak_fill) peak_fill = held_values.size();
      res.occupancy = OCC_W'(held_values.size());
      due_results.push_back(res);
    endtask

    task check_beat(logic [STAT_W-1:0] status, data_t removed, logic [OCC_W-1:0] occupancy);
      queue_result_t want;
      if (due_results.size() == 0) begin
        report($sformatf("result beat with nothing outstanding (status %0d value %0d)",
                         status, removed));
        return;
      end
      want = due_results.pop_front();
      beats_checked++;
      if (status !== want.status)
        report($sformatf("beat %0d status %0d, want %0d", beats_checked, status, want.status));
      if (removed !== want.removed)
        report($sformatf("beat %0d removed_value %0d, want %0d",
                         beats_checked, removed, want.removed));
      if (occupancy !== want.occupancy)
        report($sformatf("beat %0d occupancy %0d, want %0d",
                         beats_checked, occupancy, want.occupancy));
    endtask
  endclass

endpackage

### bench/sorted_priority_queue_tb.sv
// sorted_priority_queue_tb: randomized bench for sorted_priority_queue with a
// model-based scoreboard. Depends on spq_pkg and spq_check_pkg.
module sorted_priority_queue_tb;
  import spq_pkg::*;
  import spq_check_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_BEATS  = 250;
  localparam int NUM_PHASES   = 7;
  localparam int DRAIN_CYCLES = 8;   // wait after draining so stray result beats can show up

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     in_func = FUNC_INSERT;
  data_t                    in_value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [STAT_W-1:0]        out_status;
  data_t                    out_removed_value;
  logic [OCC_W-1:0]         out_occupancy;

  int                       cycle_count = 0;
  bit                       sender_calm = 1'b0;   // no idle gaps on the input side
  queue_scoreboard          sb = new();

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sorted_priority_queue u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_removed_value (out_removed_value),
    .out_occupancy     (out_occupancy)
  );

  // Both channels are sampled in one process at the edge, input first, so the
  // model is always updated before the matching result beat can show up.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_op(func_t'(in_func), in_value);
      if (out_valid && !out_stall) sb.check_beat(out_status, out_removed_value, out_occupancy);
    end
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("TIMEOUT after %0d cycles, %0d results outstanding", cycle_count, sb.pending());
    $display("*** FAILED ***");
    $finish;
  end

  // Mostly zero or short gaps, now and then a long one.
  function automatic int idle_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Value mix: full-range noise for bit coverage, a narrow band so duplicates
  // pile up (arrival order among equals), and the signed extremes.
  function automatic data_t pick_value();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 4) return data_t'($urandom);
    if (roll < 7) return data_t'($signed($urandom_range(0, 15)) - 8);
    case ($urandom_range(0, 3))
      0:       return data_t'(32'h7fff_ffff);
      1:       return data_t'(32'h8000_0000);
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  // Drive one beat and hold it until accepted. Valid stays high straight into
  // the next beat when no gap follows, so it is never dropped and re-raised
  // in the same step.
  task automatic send_op(func_t op, data_t value);
    int gap;
    in_valid <= 1'b1;
    in_func  <= op;
    in_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    gap = sender_calm ? 0 : idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold the sender off until every outstanding result has been taken.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Result-side backpressure: runs of ready (some long), at times a stall burst.
  // Stall is only dropped after a burst, so back-to-back ready runs do not
  // write it twice in one step.
  initial begin
    int run;
    int gap;
    wait (rst_n);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
      if (out_stall) out_stall <= 1'b0;
      repeat (run) @(posedge clk);
      gap = idle_gap();
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin
    int ins_pct [NUM_PHASES] = '{70, 30, 50, 85, 15, 50, 60};
    func_t op;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: remove from empty, fill to the brim with extremes and
    // duplicates, two refused inserts (the largest and smallest values), then
    // three removes that must come out largest first.
    send_op(FUNC_REMOVE, data_t'(32'h5a5a_a5a5));
    send_op(FUNC_INSERT, '0);
    send_op(FUNC_INSERT, data_t'(32'h7fff_ffff));
    send_op(FUNC_INSERT, data_t'(32'h8000_0000));
    send_op(FUNC_INSERT, '1);
    send_op(FUNC_INSERT, data_t'(1));
    send_op(FUNC_INSERT, '1);
    send_op(FUNC_INSERT, '0);
    repeat (9) send_op(FUNC_INSERT, pick_value());
    send_op(FUNC_INSERT, data_t'(32'h7fff_ffff));
    send_op(FUNC_INSERT, data_t'(32'h8000_0000));
    repeat (3) send_op(FUNC_REMOVE, data_t'($urandom));
    wait_drained();

    // Random phases with shifting insert/remove mix so the queue swings
    // between full and empty; some phases run the sender without gaps.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      sender_calm = (ph == 2) || (ph == 5);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        op = ($urandom_range(0, 99) < ins_pct[ph]) ? FUNC_INSERT : FUNC_REMOVE;
        send_op(op, pick_value());
      end
      if (ph == 3) wait_drained();
    end
    sender_calm = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));

    $display("Covered %0d inserts (%0d refused as overflow) and %0d removes (%0d underflow),",
             sb.n_insert, sb.n_overflow, sb.n_remove, sb.n_underflow);
    $display("peak fill %0d of %0d, %0d result beats checked, %0d mismatches.",
             sb.peak_fill, DEPTH, sb.beats_checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### files.f
src/spq_pkg.sv
src/spq_cell.sv
src/sorted_priority_queue.sv
bench/spq_check_pkg.sv
bench/sorted_priority_queue_tb.sv
